// ===== hdl/scd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scd_pkg - shared types and constants of the serial command decoder
// command record, queue status, state encodings, action and effect codes
// ----------------------------------------------------------------------------
package scd_pkg;

   // action numbers that carry an effect
   localparam logic [6:0] ACT_HDD_POWER = 7'd1;
   localparam logic [6:0] ACT_MOTOR0    = 7'd10;
   localparam logic [6:0] ACT_MOTOR1    = 7'd11;
   localparam logic [6:0] ACT_HDD_CLICK = 7'd126;

   // highest hdd index that a click may address
   localparam logic [13:0] HDD_MAX_INDEX = 14'd3;

   // tone period numerator in microseconds and restoring divider length
   localparam int          DIVIDEND_W    = 20;
   localparam logic [19:0] TONE_DIVIDEND = 20'd1000000;
   localparam logic [4:0]  DIV_LAST_STEP = 5'd19;

   typedef enum logic [2:0] {
      EFF_NONE  = 3'd0,
      EFF_POWER = 3'd1,
      EFF_STOP  = 3'd2,
      EFF_START = 3'd3,
      EFF_CLICK = 3'd4
   } effect_type;

   typedef enum logic [1:0] {
      PH_ACTION = 2'd0,
      PH_HIGH   = 2'd1,
      PH_LOW    = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE   = 2'd0,
      BK_DIVIDE = 2'd1,
      BK_EMIT   = 2'd2
   } back_state_type;

   typedef struct packed {
      logic [6:0]  action;
      logic [13:0] value;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } fifo_status_type;

endpackage
`default_nettype wire

// ===== hdl/scd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scd_front - byte parser
// collects action, high and low byte and hands finished commands to the queue
// ----------------------------------------------------------------------------
module scd_front
   import scd_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            byte_valid,
   output logic                 byte_ready,
   input  wire logic [7:0]      byte_data,
   input  wire fifo_status_type q_status,
   output logic                 push,
   output cmd_type              push_cmd
);

   phase_type  phase_ff, phase_in;
   logic [6:0] action_ff, action_in;
   logic [6:0] high_ff, high_in;
   logic       accept;
   logic       is_action;

   assign byte_ready = !q_status.full;
   assign accept     = byte_valid && byte_ready;
   assign is_action  = byte_data[7];

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_ACTION: begin
            if (accept && is_action) phase_in = PH_HIGH;
         end
         PH_HIGH: begin
            if (accept) phase_in = is_action ? PH_ACTION : PH_LOW;
         end
         PH_LOW: begin
            if (accept) phase_in = PH_ACTION;
         end
         default: begin
            phase_in = PH_ACTION;
         end
      endcase
   end

   // held bytes and command push
   always_comb begin
      action_in = action_ff;
      high_in   = high_ff;
      push      = 1'b0;
      case (phase_ff)
         PH_ACTION: begin
            if (accept && is_action) action_in = byte_data[6:0];
         end
         PH_HIGH: begin
            if (accept && !is_action) high_in = byte_data[6:0];
         end
         PH_LOW: begin
            push = accept && !is_action;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   // value = high * 127 + low
   assign push_cmd.action = action_ff;
   assign push_cmd.value  = {high_ff, 7'd0} - {7'd0, high_ff} + {7'd0, byte_data[6:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ACTION;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      high_ff   <= high_in;
   end

endmodule
`default_nettype wire

// ===== hdl/scd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scd_queue - command queue
// small register fifo between parser and executor, default depth 2
// ----------------------------------------------------------------------------
module scd_queue
   import scd_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire cmd_type   push_cmd,
   input  wire logic      pop,
   output cmd_type        pop_cmd,
   output fifo_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   assign status.full      = (count_ff == FULL_CNT);
   assign status.not_empty = (count_ff != '0);
   assign pop_cmd          = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push) else $error("push into full command queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !status.not_empty |-> !pop) else $error("pop from empty command queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT) else $error("command queue count overrun");

endmodule
`default_nettype wire

// ===== hdl/scd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scd_back - command executor
// runs the tone divider, updates motor and hdd state, holds the result item
// ----------------------------------------------------------------------------
module scd_back
   import scd_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire fifo_status_type q_status,
   input  wire cmd_type         q_cmd,
   output logic                 pop,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output logic [6:0]           out_action,
   output logic [13:0]          out_value,
   output logic [2:0]           out_effect,
   output logic [1:0]           out_target,
   output logic [18:0]          out_half,
   output logic [1:0]           out_motor,
   output logic                 out_power
);

   back_state_type         state_ff, state_in;
   cmd_type                cmd_ff;
   logic [13:0]            rem_ff;
   logic [DIVIDEND_W-1:0]  dvd_ff;
   logic [DIVIDEND_W-1:0]  quot_ff;
   logic [4:0]             step_ff;
   logic [14:0]            trial;
   logic                   trial_ok;

   logic                   valid_ff;
   logic [6:0]             action_ff;
   logic [13:0]            value_ff;
   effect_type             effect_ff, effect_in;
   logic [1:0]             target_ff, target_in;
   logic [18:0]            half_ff, half_in;
   logic [1:0]             motor_ff, motor_in;
   logic                   power_ff, power_in;

   logic                   is_motor;
   logic                   channel;
   logic [1:0]             ch_mask;
   logic                   load;

   assign is_motor = (cmd_ff.action == ACT_MOTOR0) || (cmd_ff.action == ACT_MOTOR1);
   assign channel  = cmd_ff.action[0];
   assign ch_mask  = channel ? 2'b10 : 2'b01;

   // one restoring step per cycle
   assign trial    = {rem_ff, dvd_ff[DIVIDEND_W-1]};
   assign trial_ok = (trial >= {1'b0, cmd_ff.value});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_status.not_empty) begin
               if (((q_cmd.action == ACT_MOTOR0) || (q_cmd.action == ACT_MOTOR1))
                   && (q_cmd.value != '0))
                  state_in = BK_DIVIDE;
               else
                  state_in = BK_EMIT;
            end
         end
         BK_DIVIDE: begin
            if (step_ff == DIV_LAST_STEP) state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (!valid_ff || out_ready) state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      pop  = 1'b0;
      load = 1'b0;
      case (state_ff)
         BK_IDLE:   pop  = q_status.not_empty;
         BK_EMIT:   load = !valid_ff || out_ready;
         default: begin
            pop  = 1'b0;
            load = 1'b0;
         end
      endcase
   end

   // effect of the finished command
   always_comb begin
      effect_in = EFF_NONE;
      target_in = '0;
      half_in   = '0;
      motor_in  = motor_ff;
      power_in  = power_ff;
      case (cmd_ff.action)
         ACT_HDD_POWER: begin
            effect_in = EFF_POWER;
            power_in  = (cmd_ff.value != '0);
         end
         ACT_HDD_CLICK: begin
            if (cmd_ff.value <= HDD_MAX_INDEX) begin
               effect_in = EFF_CLICK;
               target_in = cmd_ff.value[1:0];
            end
         end
         default: begin
            if (is_motor) begin
               target_in = {1'b0, channel};
               if (cmd_ff.value == '0) begin
                  effect_in = EFF_STOP;
                  motor_in  = motor_ff & ~ch_mask;
               end else begin
                  effect_in = EFF_START;
                  half_in   = quot_ff[DIVIDEND_W-1:1];
                  motor_in  = motor_ff | ch_mask;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
         motor_ff <= '0;
         power_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            valid_ff <= 1'b1;
            motor_ff <= motor_in;
            power_ff <= power_in;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff  <= q_cmd;
         rem_ff  <= '0;
         dvd_ff  <= TONE_DIVIDEND;
         quot_ff <= '0;
         step_ff <= '0;
      end else if (state_ff == BK_DIVIDE) begin
         rem_ff  <= trial_ok ? 14'(trial - {1'b0, cmd_ff.value}) : trial[13:0];
         dvd_ff  <= {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         quot_ff <= {quot_ff[DIVIDEND_W-2:0], trial_ok};
         step_ff <= step_ff + 1'b1;
      end
      if (load) begin
         action_ff <= cmd_ff.action;
         value_ff  <= cmd_ff.value;
         effect_ff <= effect_in;
         target_ff <= target_in;
         half_ff   <= half_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_action = action_ff;
   assign out_value  = value_ff;
   assign out_effect = effect_ff;
   assign out_target = target_ff;
   assign out_half   = half_ff;
   assign out_motor  = motor_ff;
   assign out_power  = power_ff;

   a_start_has_period: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (effect_ff == EFF_START) |-> (half_ff != '0) && (motor_ff[target_ff[0]]))
      else $error("channel start without period or enable");

   a_no_period_else: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (effect_ff != EFF_START) |-> (half_ff == '0))
      else $error("period reported for non-start effect");

   a_divide_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIVIDE) |-> (step_ff <= DIV_LAST_STEP))
      else $error("divider ran past its last step");

endmodule
`default_nettype wire

// ===== hdl/serial_command_decoder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// serial_command_decoder_unit - serial command decoder
// turns a stream of received bytes into decoded motor and hdd commands
// ----------------------------------------------------------------------------
// input: one byte per cycle while the command queue has room
// path: the last byte goes into the queue, the back end pops it and, for a motor
//    start, runs the 20-step restoring divider before the result register loads
// back end: one command at a time, the next pop only after the result loads
// reset: synchronous, clears parse phase, queue, motor enables and hdd power
// ----------------------------------------------------------------------------
module serial_command_decoder_unit
   import scd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   // byte side
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_byte
   // result side
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // cmd_action, cmd_value, target, half_period,
                                         // motor_enables, hdd_power, zero pad
   output logic [2:0]       rsp_tuser    // effect
);

   fifo_status_type q_status;
   cmd_type         push_cmd;
   cmd_type         q_cmd;
   logic            push;
   logic            pop;

   logic [6:0]      out_action;
   logic [13:0]     out_value;
   logic [2:0]      out_effect;
   logic [1:0]      out_target;
   logic [18:0]     out_half;
   logic [1:0]      out_motor;
   logic            out_power;

   // front end: parses bytes, stalls only when the queue is full
   scd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_ready (req_tready),
      .byte_data  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // decouples parsing from the slow divide in the back end
   scd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (q_cmd),
      .status   (q_status)
   );

   // back end: executes one command at a time into the output register
   scd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_cmd      (q_cmd),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_action (out_action),
      .out_value  (out_value),
      .out_effect (out_effect),
      .out_target (out_target),
      .out_half   (out_half),
      .out_motor  (out_motor),
      .out_power  (out_power)
   );

   // result packing, lowest field first
   assign rsp_tdata = {3'd0, out_power, out_motor, out_half, out_target,
                       out_value, out_action};
   assign rsp_tuser = out_effect;

endmodule
`default_nettype wire
